FILE: sv/csq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the chord step sequencer.
// Depends on nothing; csq_mod_unit and chord_step_sequencer import it.
package csq_pkg;

    localparam int DEF_NUM_BANKS = 4;
    localparam int DEF_MAX_STEPS = 16;

    // Step entry layout in the pattern memory: tie, gate, chord index.
    localparam int ENTRY_W   = 4;
    localparam int ENTRY_TIE  = 0;
    localparam int ENTRY_GATE = 1;
    localparam int ENTRY_CHORD_LO = 2;

    // Remainder unit operand widths. The divisor covers the ping-pong period
    // of the longest pattern allowed (2 * MAX_STEPS - 2).
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 7;

    localparam logic [31:0] RNG_SEED = 32'h9adf_ace1;
    localparam int XS_SHIFT_A = 13;
    localparam int XS_SHIFT_B = 17;
    localparam int XS_SHIFT_C = 5;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_FIRE  = 3'd1;
    localparam logic [2:0] OP_BANK  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_STOP  = 3'd4;

    localparam logic [1:0] DIR_FORWARD  = 2'd0;
    localparam logic [1:0] DIR_REVERSE  = 2'd1;
    localparam logic [1:0] DIR_PINGPONG = 2'd2;
    localparam logic [1:0] DIR_RANDOM   = 2'd3;

    localparam logic REG_STEP_COUNT = 1'b0;
    localparam logic REG_DIRECTION  = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] step_number;
        logic [1:0]  bank_index;
        logic [3:0]  entry_step;
        logic        entry_tie;
        logic        entry_gate;
        logic [1:0]  entry_chord;
    } cmd_beat_t;

    typedef struct packed {
        logic       release_valid;
        logic [1:0] released_chord;
        logic       trigger_valid;
        logic [1:0] trigger_chord;
        logic [3:0] played_step;
        logic       held;
    } res_beat_t;

    typedef struct packed {
        logic                  start;
        logic                  short_op;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIVISOR_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << XS_SHIFT_A);
        b = a ^ (a >> XS_SHIFT_B);
        return b ^ (b << XS_SHIFT_C);
    endfunction

endpackage

FILE: sv/csq_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module csq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/csq_mod_unit.sv
`timescale 1ns / 1ps
// Bit-serial remainder unit: one restoring step per cycle.
// Depends on csq_pkg for the request and response structs.
module csq_mod_unit
    import csq_pkg::*;
#(
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    // A short operation only needs the bits of a stored pattern step.
    localparam int SHORT_BITS = $clog2(MAX_STEPS);
    localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        shifted = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        if (trial[DIVISOR_W+1])
        begin
            rem_next = shifted[DIVISOR_W-1:0];
        end
        else
        begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                if (req.short_op)
                begin
                    dvd_reg   <= req.dividend << (DIVIDEND_W - SHORT_BITS);
                    count_reg <= CNT_W'(SHORT_BITS);
                end
                else
                begin
                    dvd_reg   <= req.dividend;
                    count_reg <= CNT_W'(DIVIDEND_W);
                end
            end
            else if (busy_reg)
            begin
                rem_reg   <= rem_next;
                dvd_reg   <= dvd_reg << 1;
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: sv/chord_step_sequencer.sv
`timescale 1ns / 1ps
// Chord step sequencer top level: command sequencer, pattern memory, APB registers.
// Depends on csq_pkg, csq_ram and csq_mod_unit.

// The block takes one command beat at a time and returns exactly one result
// beat for each. A fire command maps the running step number to a pattern
// step with a bit-serial remainder unit that resolves one bit per cycle; in
// forward, reverse or ping-pong mode the unit reduces the whole 32-bit step
// number. Random mode runs the unit twice, first over the stored next step
// and then over the new xorshift word; a ping-pong pattern of length one
// skips the unit. Write, bank, start and stop commands go from acceptance
// straight to the finishing state. The pattern table lives in a synchronous
// RAM with no clearing pass: a step must be written before it is fired. The
// result sits in an output register, so a new command is taken while the
// previous result still waits on the result channel; a finished result only
// stalls the sequencer when the register is still full. Configuration writes
// go through the APB port and are meant for idle periods only.
module chord_step_sequencer
    import csq_pkg::*;
#(
    parameter int NUM_BANKS = DEF_NUM_BANKS,
    parameter int MAX_STEPS = DEF_MAX_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  cmd_beat_t   cmd,
    output logic        res_valid,
    input  logic        res_stall,
    output res_beat_t   res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH  = NUM_BANKS * MAX_STEPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int STEP_W = $clog2(MAX_STEPS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_A,
        S_DIV_B,
        S_READ,
        S_FINAL
    } state_t;

    // Configuration registers.
    logic [4:0] step_count_reg;
    logic [1:0] direction_reg;
    logic       cfg_write;

    // Sequencer state.
    state_t            state_reg;
    cmd_beat_t         item_reg;
    logic [STEP_W-1:0] pstep_reg;
    logic [31:0]       rng_reg;
    logic [STEP_W-1:0] nrs_reg;
    logic [1:0]        bank_reg;
    logic              sounding_reg;
    logic [1:0]        chord_reg;
    res_beat_t         res_reg;
    logic              res_valid_reg;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic [DIVISOR_W-1:0] len;
    logic [DIVISOR_W-1:0] period;
    logic [DIVISOR_W-1:0] rem;
    logic [STEP_W-1:0]    pstep_first;
    logic [31:0]          rng_next;
    div_req_t             div_req;
    div_rsp_t             div_rsp;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [ENTRY_W-1:0] entry;

    res_beat_t  res_next;
    logic       sounding_next;
    logic [1:0] chord_next;
    logic [1:0] bank_next;
    logic [1:0] bank_req;

    // ------------------------------------------------------------------
    // APB register file. Only the word address bit selects a register.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_count_reg <= 5'd16;
            direction_reg  <= DIR_FORWARD;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_STEP_COUNT: step_count_reg <= pwdata[4:0];
                REG_DIRECTION:  direction_reg  <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STEP_COUNT: prdata = {27'd0, step_count_reg};
            REG_DIRECTION:  prdata = {30'd0, direction_reg};
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pattern length and step mapping.
    // ------------------------------------------------------------------
    always_comb
    begin
        if (step_count_reg == 5'd0)
        begin
            len = DIVISOR_W'(1);
        end
        else if (int'(step_count_reg) > MAX_STEPS)
        begin
            len = DIVISOR_W'(MAX_STEPS);
        end
        else
        begin
            len = DIVISOR_W'(step_count_reg);
        end
    end

    // The period wraps correctly in DIVISOR_W bits even for the longest pattern.
    assign period   = (len << 1) - DIVISOR_W'(2);
    assign rem      = div_rsp.remainder;
    assign rng_next = xorshift32(rng_reg);

    always_comb
    begin
        unique case (direction_reg)
            DIR_REVERSE:  pstep_first = STEP_W'(len - DIVISOR_W'(1) - rem);
            DIR_PINGPONG: pstep_first = (rem < len) ? STEP_W'(rem) : STEP_W'(period - rem);
            default:      pstep_first = STEP_W'(rem);
        endcase
    end

    assign cmd_stall = (state_reg != S_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign out_free  = !res_valid_reg || !res_stall;
    assign commit    = (state_reg == S_FINAL) && out_free;

    always_comb
    begin
        div_req = '0;
        if (accept && (cmd.op == OP_FIRE))
        begin
            div_req.start    = !((direction_reg == DIR_PINGPONG) && (len == DIVISOR_W'(1)));
            div_req.short_op = (direction_reg == DIR_RANDOM);
            div_req.divisor  = (direction_reg == DIR_PINGPONG) ? period : len;
            div_req.dividend = (direction_reg == DIR_RANDOM) ?
                               DIVIDEND_W'(nrs_reg) : cmd.step_number;
        end
        else if ((state_reg == S_DIV_A) && div_rsp.done && (direction_reg == DIR_RANDOM))
        begin
            // Second pass draws the next random step from the advanced word.
            div_req.start    = 1'b1;
            div_req.divisor  = len;
            div_req.dividend = rng_next;
        end
    end

    csq_mod_unit #(
        .MAX_STEPS (MAX_STEPS)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Pattern memory. Writes happen as the write command is taken; a fire
    // reads one entry of the current bank once the step is known.
    // ------------------------------------------------------------------
    assign wr_en   = accept && (cmd.op == OP_WRITE) && (int'(cmd.bank_index) < NUM_BANKS)
                     && (int'(cmd.entry_step) < MAX_STEPS);
    assign wr_addr = ADDR_W'(int'(cmd.bank_index) * MAX_STEPS + int'(cmd.entry_step));
    assign rd_en   = (state_reg == S_READ);
    assign rd_addr = ADDR_W'(int'(bank_reg) * MAX_STEPS + int'(pstep_reg));

    csq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({cmd.entry_chord, cmd.entry_gate, cmd.entry_tie}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    // ------------------------------------------------------------------
    // Result and chord state for the finishing command.
    // ------------------------------------------------------------------
    assign bank_req = (int'(item_reg.bank_index) >= NUM_BANKS) ?
                      2'(NUM_BANKS - 1) : item_reg.bank_index;

    always_comb
    begin
        res_next      = '0;
        sounding_next = sounding_reg;
        chord_next    = chord_reg;
        bank_next     = bank_reg;
        unique case (item_reg.op)
            OP_FIRE:
            begin
                res_next.played_step = 4'(pstep_reg);
                if (entry[ENTRY_TIE])
                begin
                    res_next.held = 1'b1;
                end
                else
                begin
                    res_next.release_valid  = sounding_reg;
                    res_next.released_chord = sounding_reg ? chord_reg : 2'd0;
                    sounding_next           = 1'b0;
                    if (entry[ENTRY_GATE])
                    begin
                        chord_next             = entry[ENTRY_CHORD_LO +: 2];
                        sounding_next          = 1'b1;
                        res_next.trigger_valid = 1'b1;
                        res_next.trigger_chord = entry[ENTRY_CHORD_LO +: 2];
                    end
                end
            end
            OP_BANK:
            begin
                if (bank_req != bank_reg)
                begin
                    res_next.release_valid  = sounding_reg;
                    res_next.released_chord = sounding_reg ? chord_reg : 2'd0;
                    sounding_next           = 1'b0;
                    bank_next               = bank_req;
                end
            end
            OP_START:
            begin
                sounding_next = 1'b0;
            end
            OP_STOP:
            begin
                res_next.release_valid  = sounding_reg;
                res_next.released_chord = sounding_reg ? chord_reg : 2'd0;
                sounding_next           = 1'b0;
            end
            default:
            begin
                // Writes and unknown commands return an empty beat.
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pstep_reg     <= '0;
            rng_reg       <= RNG_SEED;
            nrs_reg       <= '0;
            bank_reg      <= 2'd0;
            sounding_reg  <= 1'b0;
            chord_reg     <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            // A beat that leaves as the next one is committed is simply replaced.
            if (res_valid_reg && !res_stall && !commit)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= cmd;
                        if (cmd.op == OP_FIRE)
                        begin
                            pstep_reg <= '0;
                            state_reg <= div_req.start ? S_DIV_A : S_READ;
                        end
                        else
                        begin
                            state_reg <= S_FINAL;
                        end
                    end
                end
                S_DIV_A:
                begin
                    if (div_rsp.done)
                    begin
                        pstep_reg <= pstep_first;
                        if (direction_reg == DIR_RANDOM)
                        begin
                            rng_reg   <= rng_next;
                            state_reg <= S_DIV_B;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_DIV_B:
                begin
                    if (div_rsp.done)
                    begin
                        nrs_reg   <= STEP_W'(rem);
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_FINAL;
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        res_reg       <= res_next;
                        res_valid_reg <= 1'b1;
                        sounding_reg  <= sounding_next;
                        chord_reg     <= chord_next;
                        bank_reg      <= bank_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ------------------------------------------------------------------
    // Checks.
    // ------------------------------------------------------------------
    a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == S_DIV_A) || (state_reg == S_DIV_B)))
        else $error("remainder finished outside a divide state");

    a_read_then_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_FINAL))
        else $error("pattern read not followed by the finishing state");

    a_release_needs_sound: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && res_next.release_valid) |-> sounding_reg)
        else $error("release issued with nothing sounding");

    a_trigger_sounds: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && res_next.trigger_valid) |=>
        (sounding_reg && (chord_reg == $past(res_next.trigger_chord))))
        else $error("triggered chord not recorded as sounding");

    a_stalled_final_waits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINAL) && res_valid_reg && res_stall) |=>
        ((state_reg == S_FINAL) && res_valid_reg))
        else $error("result overwritten while the output register was full");

endmodule
